[rtl/int_vector_table_defines.svh]
// Assertion macros for the checker file of the vector table.
// Depends on nothing; the user supplies clk and arst_n in scope.
`ifndef INT_VECTOR_TABLE_DEFINES_SVH
`define INT_VECTOR_TABLE_DEFINES_SVH

// Clocked assertion, held off while reset is active
`define IVT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication built on the one above
`define IVT_ASSERT_IMP(lbl, ante, cons, msg) \
	`IVT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[rtl/ivt_pkg.sv]
// Types and codes for the vector table: request/response words, operation
// and status codes, sequencer states. No dependencies.
package ivt_pkg;

	// operation codes
	localparam logic [2:0] FN_APPEND = 3'd0;
	localparam logic [2:0] FN_SET    = 3'd1;
	localparam logic [2:0] FN_GET    = 3'd2;
	localparam logic [2:0] FN_DELETE = 3'd3;
	localparam logic [2:0] FN_SEARCH = 3'd4;
	localparam logic [2:0] FN_COUNT  = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// request word
	typedef struct packed {
		logic [2:0]         func;
		logic [5:0]         index;
		logic signed [31:0] value;
	} req_t;

	// response word
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data;
		logic               found;
		logic [5:0]         position;
		logic [6:0]         count;
	} rsp_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_GET,
		S_DEL,
		S_SRCH,
		S_DONE
	} state_t;

endpackage

[rtl/ivt_store.sv]
// Entry storage of the vector table: one write port, one registered read port.
// No package dependency.
module ivt_store #(
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address collision
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/int_vector_table.sv]
// Vector table top: sequencer around ivt_store; uses ivt_pkg.
// Append, set, count and bad-index requests go straight to the done state;
// get reads in S_GET, delete shifts entries down in S_DEL, search scans in S_SRCH.
// One request at a time, set by the single memory read port walked by the
// shared compare/increment unit; ready again in the cycle the response loads.
// Reset (arst_n low, async) empties the table; entry contents are not cleared.
module int_vector_table #(
	parameter int CAPACITY = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ivt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ivt_pkg::rsp_t rsp
);
	import ivt_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int FW = $clog2(CAPACITY + 1);
	localparam int CW = (FW > 6) ? FW : 6;

	state_t        state_q, state_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [FW-1:0] fill_q, fill_d;
	req_t          req_q;
	rsp_t          res_q, res_d;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;

	logic          acc;
	logic          idx_ok;
	logic          full;
	logic [FW-1:0] nxt;
	logic          more;
	logic          hit;
	logic          out_free;
	logic [CW-1:0] idx_ext;

	ivt_store #(.DEPTH(CAPACITY)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// handshake signals and the shared compare and increment unit
	assign req_ready = (state_q == S_IDLE);
	assign acc       = req_valid && req_ready;
	assign idx_ext   = CW'(req.index);
	assign idx_ok    = idx_ext < CW'(fill_q);
	assign full      = (fill_q == FW'(CAPACITY));
	assign nxt       = FW'(ptr_q) + FW'(1);
	assign more      = nxt < fill_q;
	assign hit       = (mem_rdata == req_q.value);
	assign out_free  = !rsp_valid_q || rsp_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.func)
						FN_GET:    state_d = idx_ok ? S_GET : S_DONE;
						FN_DELETE: state_d = idx_ok ? S_DEL : S_DONE;
						FN_SEARCH: state_d = (fill_q != '0) ? S_SRCH : S_DONE;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_GET:  state_d = S_DONE;
			S_DEL:  state_d = more ? S_DEL : S_DONE;
			S_SRCH: state_d = (hit || !more) ? S_DONE : S_SRCH;
			S_DONE: state_d = out_free ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = '0;
		mem_raddr = ptr_q;
		fill_d    = fill_q;
		ptr_d     = ptr_q;
		res_d     = res_q;
		case (state_q)
			S_IDLE: begin
				mem_raddr = AW'(idx_ext);
				if (acc) begin
					res_d        = '0;
					res_d.status = ST_OK;
					case (req.func)
						FN_APPEND: begin
							if (full) begin
								res_d.status = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(fill_q);
								mem_wdata = req.value;
								fill_d    = fill_q + FW'(1);
							end
						end
						FN_SET: begin
							if (idx_ok) begin
								mem_we    = 1'b1;
								mem_waddr = AW'(idx_ext);
								mem_wdata = req.value;
							end else begin
								res_d.status = ST_BAD_INDEX;
							end
						end
						FN_GET: begin
							if (!idx_ok) res_d.status = ST_BAD_INDEX;
						end
						FN_DELETE: begin
							// prefetch the entry that moves into the deleted slot
							mem_raddr = AW'(idx_ext + CW'(1));
							ptr_d     = AW'(idx_ext);
							if (!idx_ok) res_d.status = ST_BAD_INDEX;
						end
						FN_SEARCH: begin
							mem_raddr = '0;
							ptr_d     = '0;
						end
						default: ;
					endcase
				end
			end
			S_GET: begin
				res_d.data = mem_rdata;
			end
			S_DEL: begin
				// move entry ptr+1 down to ptr, clear the last slot at the end
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				if (more) begin
					mem_wdata = mem_rdata;
					mem_raddr = AW'(nxt + FW'(1));
					ptr_d     = AW'(nxt);
				end else begin
					mem_wdata = '0;
					fill_d    = fill_q - FW'(1);
				end
			end
			S_SRCH: begin
				if (hit) begin
					res_d.found    = 1'b1;
					res_d.position = 6'(ptr_q);
				end else if (more) begin
					mem_raddr = AW'(nxt);
					ptr_d     = AW'(nxt);
				end
			end
			default: ;
		endcase
		// count tracks the fill level after this cycle
		res_d.count = 7'(fill_d);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ptr_q       <= '0;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			fill_q  <= fill_d;
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (acc) begin
			req_q <= req;
		end
		if (state_q == S_DONE && out_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/ivt_checker.sv]
// Port-level checks for int_vector_table and the bind that attaches them.
// Depends on ivt_pkg and int_vector_table_defines.svh.
`include "int_vector_table_defines.svh"

module ivt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input ivt_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input ivt_pkg::rsp_t rsp
);
	import ivt_pkg::*;

	// a stalled response word holds
	`IVT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "rsp word changed while stalled")

	// one request in flight: busy right after an accept
	`IVT_ASSERT(a_busy_after_acc, req_valid && req_ready |=> !req_ready, "ready stayed high after accept")

	// failed operations return no data and no match
	`IVT_ASSERT_IMP(a_err_clean, rsp_valid && rsp.status != ST_OK, rsp.data == 0 && !rsp.found, "error word carries data")

	// a match is only reported with good status and zero data
	`IVT_ASSERT_IMP(a_found_ok, rsp_valid && rsp.found, rsp.status == ST_OK && rsp.data == 0, "found with bad status")

endmodule

bind int_vector_table ivt_checker u_ivt_checker (.*);

[tb/int_vector_table_tb.sv]
// Self-checking testbench for int_vector_table: directed and random request words,
// predicted against a shadow copy of the table kept in this file.
// Depends on ivt_pkg and the int_vector_table RTL.
module int_vector_table_tb;
	import ivt_pkg::*;

	localparam int CAPACITY     = 64;
	localparam int RANDOM_WORDS = 1200;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int DRAIN_CYCLES = 100;

	// func codes the block treats as no-ops
	localparam logic [2:0] FN_SPARE6 = 3'd6;
	localparam logic [2:0] FN_SPARE7 = 3'd7;

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_ready;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_ready;
	rsp_t  rsp;

	// shadow of the table contents and fill level
	logic signed [31:0] shadow_words [CAPACITY];
	logic [6:0]         shadow_fill;
	rsp_t               rsps_due [$];

	int  errors      = 0;
	int  cycle_count = 0;
	int  burst_left  = 0;
	bit  sender_gaps = 1;
	int  stall_left  = 0;
	int  ready_mode  = 0;

	int_vector_table #(.CAPACITY(CAPACITY)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// cycle count and run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("int_vector_table_tb: errors");
			$finish;
		end
	end

	// apply one request to the shadow table, return the response word it yields
	function automatic rsp_t vector_op(req_t r);
		rsp_t res;
		int   i;
		bit   hit;
		res = '0;
		hit = 1'b0;
		case (r.func)
			FN_APPEND: begin
				if (shadow_fill >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					shadow_words[shadow_fill] = r.value;
					shadow_fill = shadow_fill + 7'd1;
				end
			end
			FN_SET: begin
				if (r.index < shadow_fill) shadow_words[r.index] = r.value;
				else res.status = ST_BAD_INDEX;
			end
			FN_GET: begin
				if (r.index < shadow_fill) res.data = shadow_words[r.index];
				else res.status = ST_BAD_INDEX;
			end
			FN_DELETE: begin
				if (r.index < shadow_fill) begin
					for (i = int'(r.index); i + 1 < shadow_fill; i++)
						shadow_words[i] = shadow_words[i + 1];
					shadow_words[shadow_fill - 7'd1] = '0;
					shadow_fill = shadow_fill - 7'd1;
				end else begin
					res.status = ST_BAD_INDEX;
				end
			end
			FN_SEARCH: begin
				for (i = 0; i < shadow_fill; i++) begin
					if (!hit && shadow_words[i] == r.value) begin
						hit = 1'b1;
						res.found = 1'b1;
						res.position = i[5:0];
					end
				end
			end
			default: ;
		endcase
		res.count = shadow_fill;
		return res;
	endfunction

	function automatic req_t make_req(logic [2:0] func, logic [5:0] index,
			logic signed [31:0] value);
		req_t r;
		r.func  = func;
		r.index = index;
		r.value = value;
		return r;
	endfunction

	// word values leaning on the extremes and on a small pool for duplicates
	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return 32'sh0;
			3: return -32'sd1;
			4, 5: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	// random request; growing favors appends, otherwise deletes dominate
	function automatic req_t pick_request(bit growing);
		req_t r;
		int   roll;
		int   fill;
		fill    = int'(shadow_fill);
		r.index = 6'($urandom_range(0, 63));
		r.value = pick_word();
		roll    = $urandom_range(0, 99);
		if (roll < (growing ? 45 : 10))      r.func = FN_APPEND;
		else if (roll < (growing ? 55 : 20)) r.func = FN_SET;
		else if (roll < (growing ? 68 : 33)) r.func = FN_GET;
		else if (roll < (growing ? 76 : 73)) r.func = FN_DELETE;
		else if (roll < 90)                  r.func = FN_SEARCH;
		else if (roll < 97)                  r.func = FN_COUNT;
		else r.func = $urandom_range(0, 1) ? FN_SPARE6 : FN_SPARE7;

		// mostly good indexes, some just past the end or anywhere
		if (r.func == FN_SET || r.func == FN_GET || r.func == FN_DELETE) begin
			if (fill != 0 && $urandom_range(0, 9) < 8) begin
				r.index = 6'($urandom_range(0, fill - 1));
			end else begin
				case ($urandom_range(0, 2))
					0: if (fill < CAPACITY) r.index = fill[5:0];
					1: r.index = 6'd63;
					default: ;
				endcase
			end
		end
		// searches mostly look for something present
		if (r.func == FN_SEARCH && fill != 0 && $urandom_range(0, 9) < 7)
			r.value = shadow_words[$urandom_range(0, fill - 1)];
		return r;
	endfunction

	// send one request word; caller is at a rising edge
	task automatic send_word(req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = sender_gaps ? $urandom_range(0, 12) : 0;
			if (gap != 0) begin
				req_valid <= 1'b0;
				req       <= make_req(3'($urandom), 6'($urandom), $urandom);
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		rsps_due.push_back(vector_op(r));
	endtask

	// receiver: switches between always ready, random ready and ready with stall bursts
	always @(posedge clk) begin
		if (cycle_count % 256 == 0) ready_mode = $urandom_range(0, 2);
		if (stall_left != 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else begin
			case (ready_mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= 1'($urandom_range(0, 1));
				default: begin
					rsp_ready <= 1'b1;
					if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 30);
				end
			endcase
		end
	end

	// compare each response word with the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsps_due.size() == 0) begin
				$error("response with none pending: %p", rsp);
				errors++;
			end else begin
				want = rsps_due.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					errors++;
				end
				if (rsp.data !== want.data) begin
					$error("data: expected %0d, got %0d", want.data, rsp.data);
					errors++;
				end
				if (rsp.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, rsp.found);
					errors++;
				end
				if (rsp.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, rsp.position);
					errors++;
				end
				if (rsp.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, rsp.count);
					errors++;
				end
			end
		end
	end

	// every operation but append on an empty table, unused func codes included
	task automatic test_empty_table();
		send_word(make_req(FN_COUNT, 6'd0, 32'sd0));
		send_word(make_req(FN_GET, 6'd0, 32'sd0));
		send_word(make_req(FN_SET, 6'd0, 32'sd5));
		send_word(make_req(FN_DELETE, 6'd0, 32'sd0));
		send_word(make_req(FN_SEARCH, 6'd0, 32'sd0));
		send_word(make_req(FN_SPARE6, 6'd63, -32'sd1));
		send_word(make_req(FN_SPARE7, 6'd0, 32'sd0));
	endtask

	// extreme words, bad indexes at and past the end, shift on delete
	task automatic test_extremes();
		send_word(make_req(FN_APPEND, 6'd0, 32'sh7fff_ffff));
		send_word(make_req(FN_APPEND, 6'd63, 32'sh8000_0000));
		send_word(make_req(FN_APPEND, 6'd0, 32'sd0));
		send_word(make_req(FN_APPEND, 6'd0, -32'sd1));
		send_word(make_req(FN_GET, 6'd0, 32'sd0));
		send_word(make_req(FN_GET, 6'd3, 32'sd0));
		send_word(make_req(FN_GET, 6'd4, 32'sd0));
		send_word(make_req(FN_GET, 6'd63, 32'sd0));
		send_word(make_req(FN_SET, 6'd1, 32'sd1));
		send_word(make_req(FN_SEARCH, 6'd0, 32'sh8000_0000));
		send_word(make_req(FN_SEARCH, 6'd0, -32'sd1));
		send_word(make_req(FN_DELETE, 6'd0, 32'sd0));
		send_word(make_req(FN_GET, 6'd0, 32'sd0));
		send_word(make_req(FN_DELETE, 6'd2, 32'sd0));
		send_word(make_req(FN_SET, 6'd2, 32'sd9));
		send_word(make_req(FN_COUNT, 6'd0, 32'sd0));
		send_word(make_req(FN_SEARCH, 6'd0, 32'sd12345));
	endtask

	// random traffic cycling the table between empty and full
	task automatic test_random_traffic();
		bit growing;
		growing = 1'b1;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 150 == 0) sender_gaps = ($urandom_range(0, 2) != 0);
			send_word(pick_request(growing));
			if (growing && shadow_fill == CAPACITY && $urandom_range(0, 7) == 0)
				growing = 1'b0;
			else if (!growing && shadow_fill == 0 && $urandom_range(0, 3) == 0)
				growing = 1'b1;
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		rsp_ready   = 1'b0;
		shadow_fill = '0;
		for (int i = 0; i < CAPACITY; i++) shadow_words[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_extremes();
		test_random_traffic();

		req_valid <= 1'b0;
		while (rsps_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("int_vector_table_tb: clean");
		end else begin
			$display("int_vector_table_tb: errors");
		end
		$finish;
	end

endmodule
